// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bchs_pkg.sv =====
// Package: shared types and constants of the bounded chained hash set.
`timescale 1ns / 1ps
`default_nettype none
package bchs_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int ENTRIES_DEF = 1024;

  localparam int CMD_W    = 2;
  localparam int KEYH_W   = 32;
  localparam int HANDLE_W = 64;
  localparam int SLOT_W   = 8;
  localparam int IDX_W    = 10;
  localparam int STATUS_W = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_FIND   = 2'd1,
    CMD_INDEX  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_HASH,
    S_HEADW,
    S_WALK,
    S_MISS,
    S_IDX,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/bchs_mod.sv =====
// Bucket selection: page number modulo the bucket count, registered result.
`timescale 1ns / 1ps
`default_nettype none
module bchs_mod #(
  parameter int BUCKETS = bchs_pkg::BUCKETS_DEF,
  parameter int BW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [bchs_pkg::KEYH_W-1:0] value,
  output      logic                        done,
  output      logic [BW-1:0]               rem
);
  import bchs_pkg::*;

  localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);
  localparam int RW   = BW + 1;

  logic          done_r;
  logic [BW-1:0] rem_r;

  assign done = done_r;
  assign rem  = rem_r;

  generate
    if (POW2) begin : g_mask
      // Power of two: the remainder is a mask of the low bits
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          done_r <= 1'b0;
        end else begin
          done_r <= start;
        end
        if (start) begin
          rem_r <= (BUCKETS == 1) ? '0 : BW'(value);
        end
      end
    end else begin : g_iter
      // Restoring remainder, four bits per cycle, most significant bits first
      logic                  busy_r;
      logic [2:0]            cnt_r;
      logic [KEYH_W-1:0]     val_r;
      logic [BW-1:0]         r_r;
      logic [BW-1:0]         r_nxt;

      always_comb begin
        logic [RW-1:0] t;
        t     = '0;
        r_nxt = r_r;
        for (int i = 0; i < 4; i++) begin
          t = {r_nxt, val_r[KEYH_W-1-i]};
          if (t >= RW'(BUCKETS)) begin
            t = t - RW'(BUCKETS);
          end
          r_nxt = t[BW-1:0];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          busy_r <= 1'b0;
          done_r <= 1'b0;
          cnt_r  <= '0;
        end else begin
          done_r <= 1'b0;
          if (start) begin
            busy_r <= 1'b1;
            cnt_r  <= '0;
          end else if (busy_r) begin
            cnt_r <= cnt_r + 3'd1;
            if (cnt_r == 3'd7) begin
              busy_r <= 1'b0;
              done_r <= 1'b1;
            end
          end
        end
        if (start) begin
          val_r <= value;
          r_r   <= '0;
        end else if (busy_r) begin
          val_r <= val_r << 4;
          r_r   <= r_nxt;
          if (cnt_r == 3'd7) begin
            rem_r <= r_nxt;
          end
        end
      end
    end
  endgenerate

endmodule
`default_nettype wire

// ===== rtl/bchs_head_ram.sv =====
// Bucket head memory: valid bit and head position per bucket.
`timescale 1ns / 1ps
`default_nettype none
module bchs_head_ram #(
  parameter int DEPTH = bchs_pkg::BUCKETS_DEF,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);
  import bchs_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bchs_entry_ram.sv =====
// Record memory: key, handle, slot and chain link per fill position.
`timescale 1ns / 1ps
`default_nettype none
module bchs_entry_ram #(
  parameter int DEPTH = bchs_pkg::ENTRIES_DEF,
  parameter int AW    = 10,
  parameter int DW    = 147
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output      logic [DW-1:0] rdata
);
  import bchs_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  assign rdata = rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bounded_chained_hash_set.sv =====
// Top level: command sequencer of the bounded chained hash set.
//
//  channel | direction | transaction
//  in_     | input     | one command with key, handle, slot and index
//  out_    | output    | one result per command
//
// Find and append walk the bucket chain, and each link walked is one read of the
// record memory; bucket selection runs the iterative remainder when the bucket
// count is not a power of two. Find by index reads one record, or answers with a
// range error and no read when the index is out of range.
// After reset and on every clear, the head memory is swept one bucket per cycle;
// no command is taken meanwhile. A stalled result is held while the next command
// is taken and worked on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bounded_chained_hash_set #(
  parameter int BUCKETS = bchs_pkg::BUCKETS_DEF,
  parameter int ENTRIES = bchs_pkg::ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic [bchs_pkg::CMD_W-1:0]    in_command,
  input  wire logic [bchs_pkg::KEYH_W-1:0]   in_space_id,
  input  wire logic [bchs_pkg::KEYH_W-1:0]   in_page_no,
  input  wire logic [bchs_pkg::HANDLE_W-1:0] in_block_handle,
  input  wire logic [bchs_pkg::SLOT_W-1:0]   in_slot_id,
  input  wire logic [bchs_pkg::IDX_W-1:0]    in_entry_index,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [bchs_pkg::STATUS_W-1:0] out_status,
  output      logic [bchs_pkg::IDX_W-1:0]    out_hit_index,
  output      logic [bchs_pkg::HANDLE_W-1:0] out_hit_handle,
  output      logic [bchs_pkg::SLOT_W-1:0]   out_hit_slot,
  output      logic [bchs_pkg::KEYH_W-1:0]   out_hit_space,
  output      logic [bchs_pkg::KEYH_W-1:0]   out_hit_page
);
  import bchs_pkg::*;

  localparam int BW   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int SW   = CW + 1;
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;
  localparam int HW   = IW + 1;
  localparam int KW   = 2 * KEYH_W;
  localparam int EW   = KW + HANDLE_W + SLOT_W + 1 + IW;
  // Record layout, low to high: next, next valid, slot, handle, key
  localparam int NV_B = IW;
  localparam int SL_L = IW + 1;
  localparam int HD_L = SL_L + SLOT_W;
  localparam int KY_L = HD_L + HANDLE_W;

  state_t state_r, state_nxt;

  // Control registers
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [BW-1:0]  sweep_r, sweep_nxt;
  logic           clr_pend_r, clr_pend_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [SW-1:0]  steps_r, steps_nxt;

  // Command payload registers
  cmd_t                cmd_r;
  logic [KEYH_W-1:0]   space_r, page_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [IDX_W-1:0]    idx_r;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [HW-1:0]       head_r, head_nxt;
  logic [IW-1:0]       cur_r, cur_nxt;

  // Pending result and output registers
  status_t             res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_index_r, res_index_nxt;
  logic [HANDLE_W-1:0] res_handle_r, res_handle_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;
  logic [KW-1:0]       res_key_r, res_key_nxt;
  logic                out_load;
  status_t             out_status_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [HANDLE_W-1:0] out_handle_r;
  logic [SLOT_W-1:0]   out_slot_r;
  logic [KW-1:0]       out_key_r;

  // Memory ports
  logic          head_we, head_re;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [HW-1:0] head_wdata, head_q;
  logic          ent_we, ent_re;
  logic [IW-1:0] ent_waddr, ent_raddr;
  logic [EW-1:0] ent_wdata, ent_q;

  logic          hash_done;
  logic [BW-1:0] hash_rem;
  logic          in_acc;
  logic [KW-1:0] key_r;
  logic [IW-1:0] q_next;

  assign in_acc = in_valid && !in_stall;
  assign key_r  = {space_r, page_r};
  assign q_next = ent_q[IW-1:0];

  bchs_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_acc && (in_command == CMD_APPEND || in_command == CMD_FIND)),
    .value (in_page_no),
    .done  (hash_done),
    .rem   (hash_rem)
  );

  bchs_head_ram #(.DEPTH(BUCKETS), .AW(BW), .DW(HW)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (head_waddr),
    .wdata (head_wdata),
    .re    (head_re),
    .raddr (head_raddr),
    .rdata (head_q)
  );

  bchs_entry_ram #(.DEPTH(ENTRIES), .AW(IW), .DW(EW)) u_entry (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_SWEEP;
      fill_r      <= '0;
      sweep_r     <= '0;
      clr_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      steps_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      sweep_r     <= sweep_nxt;
      clr_pend_r  <= clr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      steps_r     <= steps_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r    <= cmd_t'(in_command);
      space_r  <= in_space_id;
      page_r   <= in_page_no;
      handle_r <= in_block_handle;
      slot_r   <= in_slot_id;
      idx_r    <= in_entry_index;
    end
    bucket_r     <= bucket_nxt;
    head_r       <= head_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_handle_r <= res_handle_nxt;
    res_slot_r   <= res_slot_nxt;
    res_key_r    <= res_key_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_handle_r <= res_handle_r;
      out_slot_r   <= res_slot_r;
      out_key_r    <= res_key_r;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    sweep_nxt      = sweep_r;
    clr_pend_nxt   = clr_pend_r;
    steps_nxt      = steps_r;
    bucket_nxt     = bucket_r;
    head_nxt       = head_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_handle_nxt = res_handle_r;
    res_slot_nxt   = res_slot_r;
    res_key_nxt    = res_key_r;
    head_we        = 1'b0;
    head_waddr     = sweep_r;
    head_wdata     = '0;
    head_re        = 1'b0;
    head_raddr     = hash_rem;
    ent_we         = 1'b0;
    ent_waddr      = IW'(fill_r);
    ent_wdata      = {key_r, handle_r, slot_r, head_r};
    ent_re         = 1'b0;
    ent_raddr      = q_next;
    out_load       = 1'b0;
    in_stall       = (state_r != S_IDLE);

    // Output register frees when its transaction completes
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      S_SWEEP: begin
        head_we   = 1'b1;
        sweep_nxt = sweep_r + BW'(1);
        if (sweep_r == BW'(BUCKETS - 1)) begin
          sweep_nxt = '0;
          if (clr_pend_r) begin
            clr_pend_nxt   = 1'b0;
            res_status_nxt = ST_OK;
            res_index_nxt  = '0;
            res_handle_nxt = '0;
            res_slot_nxt   = '0;
            res_key_nxt    = '0;
            state_nxt      = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (cmd_t'(in_command))
            CMD_APPEND, CMD_FIND: begin
              state_nxt = S_HASH;
            end
            CMD_INDEX: begin
              if (CMPW'(in_entry_index) < CMPW'(fill_r)) begin
                ent_re    = 1'b1;
                ent_raddr = IW'(in_entry_index);
                state_nxt = S_IDX;
              end else begin
                res_status_nxt = ST_RANGE;
                res_index_nxt  = '0;
                res_handle_nxt = '0;
                res_slot_nxt   = '0;
                res_key_nxt    = '0;
                state_nxt      = S_OUT;
              end
            end
            CMD_CLEAR: begin
              fill_nxt     = '0;
              sweep_nxt    = '0;
              clr_pend_nxt = 1'b1;
              state_nxt    = S_SWEEP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          head_re    = 1'b1;
          bucket_nxt = hash_rem;
          state_nxt  = S_HEADW;
        end
      end
      S_HEADW: begin
        head_nxt = head_q;
        if (head_q[IW] && (CW'(head_q[IW-1:0]) < fill_r)) begin
          ent_re    = 1'b1;
          ent_raddr = head_q[IW-1:0];
          cur_nxt   = head_q[IW-1:0];
          steps_nxt = '0;
          state_nxt = S_WALK;
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_WALK: begin
        if (ent_q[EW-1:KY_L] == key_r) begin
          res_status_nxt = (cmd_r == CMD_APPEND) ? ST_DUP : ST_OK;
          res_index_nxt  = IDX_W'(cur_r);
          res_handle_nxt = ent_q[KY_L-1:HD_L];
          res_slot_nxt   = ent_q[HD_L-1:SL_L];
          res_key_nxt    = ent_q[EW-1:KY_L];
          state_nxt      = S_OUT;
        end else if (ent_q[NV_B] && (CW'(q_next) < fill_r) &&
                     ((steps_r + SW'(1)) <= SW'(fill_r))) begin
          ent_re    = 1'b1;
          cur_nxt   = q_next;
          steps_nxt = steps_r + SW'(1);
        end else begin
          state_nxt = S_MISS;
        end
      end
      S_MISS: begin
        res_index_nxt  = '0;
        res_handle_nxt = '0;
        res_slot_nxt   = '0;
        res_key_nxt    = '0;
        state_nxt      = S_OUT;
        if (cmd_r != CMD_APPEND) begin
          res_status_nxt = ST_NOTFOUND;
        end else if (fill_r >= CW'(ENTRIES)) begin
          res_status_nxt = ST_FULL;
        end else begin
          // Store the record and push it on its bucket chain
          ent_we         = 1'b1;
          head_we        = 1'b1;
          head_waddr     = bucket_r;
          head_wdata     = {1'b1, IW'(fill_r)};
          fill_nxt       = fill_r + CW'(1);
          res_status_nxt = ST_OK;
          res_index_nxt  = IDX_W'(fill_r);
          res_handle_nxt = handle_r;
          res_slot_nxt   = slot_r;
          res_key_nxt    = key_r;
        end
      end
      S_IDX: begin
        res_status_nxt = ST_OK;
        res_index_nxt  = idx_r;
        res_handle_nxt = ent_q[KY_L-1:HD_L];
        res_slot_nxt   = ent_q[HD_L-1:SL_L];
        res_key_nxt    = ent_q[EW-1:KY_L];
        state_nxt      = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit_index  = out_index_r;
  assign out_hit_handle = out_handle_r;
  assign out_hit_slot   = out_slot_r;
  assign out_hit_space  = out_key_r[KW-1:KEYH_W];
  assign out_hit_page   = out_key_r[KEYH_W-1:0];

  // Checks
  `ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= CW'(ENTRIES), "fill count above capacity")
  `ASSERT_NEXT(a_clear_sweep, in_acc && (in_command == CMD_CLEAR),
               (state_r == S_SWEEP) && (fill_r == '0), "clear did not start sweep")
  `ASSERT_IMPL(a_no_write_in_walk, state_r == S_WALK, !ent_we && !head_we,
               "memory write during chain walk")
  `ASSERT_IMPL(a_out_from_seq, $rose(out_valid_r), $past(state_r == S_OUT),
               "result loaded outside output state")

endmodule
`default_nettype wire
